// File: rtl/core/tpc_pkg.sv
// Shared types, widths, codes and the control program of the touch calibration block.
// No dependencies; every other file of the block imports this package.
package tpc_pkg;

    localparam int COORD_BITS = 12;
    localparam int NPTS       = 3;
    localparam int IDX_W      = $clog2(NPTS);
    localparam int CNT_W      = $clog2(NPTS + 1);
    localparam int GAIN_W     = 26;
    localparam int OFFS_W     = 39;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PAIR_W     = 2 * COORD_BITS + 1;
    localparam int PROD_W     = PAIR_W + DIFF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int NSTEPS     = 37;
    localparam int PC_W       = $clog2(NSTEPS);

    localparam logic [PC_W-1:0] PC_FAIL = PC_W'(NSTEPS - 1);

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_CAL   = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef logic signed [OFFS_W-1:0] t_offs;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_OK   = 2'd1,
        ST_FEW  = 2'd2,
        ST_ZERO = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SRC_DX   = 3'd0,
        SRC_DY   = 3'd1,
        SRC_TX   = 3'd2,
        SRC_TY   = 3'd3,
        SRC_PROD = 3'd4
    } t_src;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } t_acc_op;

    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_DIV  = 3'd1,
        WR_XTX  = 3'd2,
        WR_XTY  = 3'd3,
        WR_XOFF = 3'd4,
        WR_YTX  = 3'd5,
        WR_YTY  = 3'd6,
        WR_YOFF = 3'd7
    } t_wr;

    // One control word of the program.
    typedef struct packed {
        t_src             a_src;
        logic [IDX_W-1:0] a_i;
        logic [IDX_W-1:0] a_j;
        logic             a_sub;
        t_src             b_src;
        logic [IDX_W-1:0] b_i;
        logic [IDX_W-1:0] b_j;
        logic             b_sub;
        logic             mul;
        t_acc_op          acc_op;
        t_wr              wr;
        logic             jmp_zero;
        logic [PC_W-1:0]  jmp_tgt;
        logic             done;
        t_status          status;
    } t_uword;

    typedef struct packed {
        logic clear;
        logic add;
    } t_dp_cmd;

    typedef struct packed {
        t_coord dx;
        t_coord dy;
        t_coord tx;
        t_coord ty;
    } t_point;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_fin;

    // First product of a cross term: (a0 - a2) * (b1 - b2).
    function automatic t_uword cross_lo(t_uword w, t_src a, t_src b);
        t_uword r;
        r       = w;
        r.a_src = a;
        r.a_i   = IDX_W'(0);
        r.a_j   = IDX_W'(2);
        r.a_sub = 1'b1;
        r.b_src = b;
        r.b_i   = IDX_W'(1);
        r.b_j   = IDX_W'(2);
        r.b_sub = 1'b1;
        r.mul   = 1'b1;
        return r;
    endfunction

    // Second product of a cross term: (a1 - a2) * (b0 - b2).
    function automatic t_uword cross_hi(t_uword w, t_src a, t_src b);
        t_uword r;
        r     = cross_lo(w, a, b);
        r.a_i = IDX_W'(1);
        r.b_i = IDX_W'(0);
        return r;
    endfunction

    // Touch X of point j times display coordinate of point k.
    function automatic t_uword tx_by_d(t_uword w, int j, t_src d, int k);
        t_uword r;
        r       = w;
        r.a_src = SRC_TX;
        r.a_i   = IDX_W'(j);
        r.a_j   = IDX_W'(j);
        r.a_sub = 1'b0;
        r.b_src = d;
        r.b_i   = IDX_W'(k);
        r.b_j   = IDX_W'(k);
        r.b_sub = 1'b0;
        r.mul   = 1'b1;
        return r;
    endfunction

    // Previous product times touch Y of point i.
    function automatic t_uword prod_by_ty(t_uword w, int i);
        t_uword r;
        r       = w;
        r.a_src = SRC_PROD;
        r.a_i   = IDX_W'(0);
        r.a_j   = IDX_W'(0);
        r.a_sub = 1'b0;
        r.b_src = SRC_TY;
        r.b_i   = IDX_W'(i);
        r.b_j   = IDX_W'(i);
        r.b_sub = 1'b0;
        r.mul   = 1'b1;
        return r;
    endfunction

    // Program ROM. The multiplier result is registered, so an accumulate
    // step always consumes the product issued by the step before it.
    function automatic t_uword rom_word(logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            0:  w = cross_lo(w, SRC_TX, SRC_TY);
            1:  begin w = cross_hi(w, SRC_TX, SRC_TY); w.acc_op = ACC_LOAD; end
            2:  begin w = cross_lo(w, SRC_DX, SRC_TY); w.acc_op = ACC_SUB; end
            3:  begin
                w = cross_hi(w, SRC_DX, SRC_TY);
                w.acc_op   = ACC_LOAD;
                w.wr       = WR_DIV;
                w.jmp_zero = 1'b1;
                w.jmp_tgt  = PC_FAIL;
            end
            4:  begin w = cross_lo(w, SRC_TX, SRC_DX); w.acc_op = ACC_SUB; end
            5:  begin
                w = cross_hi(w, SRC_TX, SRC_DX); w.acc_op = ACC_LOAD; w.wr = WR_XTX;
            end
            6:  begin w = cross_lo(w, SRC_DY, SRC_TY); w.acc_op = ACC_SUB; end
            7:  begin
                w = cross_hi(w, SRC_DY, SRC_TY); w.acc_op = ACC_LOAD; w.wr = WR_XTY;
            end
            8:  begin w = cross_lo(w, SRC_TX, SRC_DY); w.acc_op = ACC_SUB; end
            9:  begin
                w = cross_hi(w, SRC_TX, SRC_DY); w.acc_op = ACC_LOAD; w.wr = WR_YTX;
            end
            // X offset: six triple products, signs + - + - + -
            10: begin w = tx_by_d(w, 2, SRC_DX, 1); w.acc_op = ACC_SUB; end
            11: begin w = prod_by_ty(w, 0); w.wr = WR_YTY; end
            12: begin w = tx_by_d(w, 1, SRC_DX, 2); w.acc_op = ACC_LOAD; end
            13: w = prod_by_ty(w, 0);
            14: begin w = tx_by_d(w, 0, SRC_DX, 2); w.acc_op = ACC_SUB; end
            15: w = prod_by_ty(w, 1);
            16: begin w = tx_by_d(w, 2, SRC_DX, 0); w.acc_op = ACC_ADD; end
            17: w = prod_by_ty(w, 1);
            18: begin w = tx_by_d(w, 1, SRC_DX, 0); w.acc_op = ACC_SUB; end
            19: w = prod_by_ty(w, 2);
            20: begin w = tx_by_d(w, 0, SRC_DX, 1); w.acc_op = ACC_ADD; end
            21: w = prod_by_ty(w, 2);
            // Y offset, same pattern on display Y
            22: begin w = tx_by_d(w, 2, SRC_DY, 1); w.acc_op = ACC_SUB; end
            23: begin w = prod_by_ty(w, 0); w.wr = WR_XOFF; end
            24: begin w = tx_by_d(w, 1, SRC_DY, 2); w.acc_op = ACC_LOAD; end
            25: w = prod_by_ty(w, 0);
            26: begin w = tx_by_d(w, 0, SRC_DY, 2); w.acc_op = ACC_SUB; end
            27: w = prod_by_ty(w, 1);
            28: begin w = tx_by_d(w, 2, SRC_DY, 0); w.acc_op = ACC_ADD; end
            29: w = prod_by_ty(w, 1);
            30: begin w = tx_by_d(w, 1, SRC_DY, 0); w.acc_op = ACC_SUB; end
            31: w = prod_by_ty(w, 2);
            32: begin w = tx_by_d(w, 0, SRC_DY, 1); w.acc_op = ACC_ADD; end
            33: w = prod_by_ty(w, 2);
            34: w.acc_op = ACC_SUB;
            35: begin w.wr = WR_YOFF; w.done = 1'b1; w.status = ST_OK; end
            36: begin w.done = 1'b1; w.status = ST_ZERO; end
            default: w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/tpc_if.sv
// Request and response channel interfaces of the touch calibration block.
// Depends on tpc_pkg for field widths and types.
interface tpc_in_if;
    import tpc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    t_coord     display_x;
    t_coord     display_y;
    t_coord     touch_x;
    t_coord     touch_y;
    modport source(output valid, mode, display_x, display_y, touch_x, touch_y, input ready);
    modport sink(input valid, mode, display_x, display_y, touch_x, touch_y, output ready);
endinterface

interface tpc_out_if;
    import tpc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    t_gain      divider;
    t_gain      x_from_touch_x;
    t_gain      x_from_touch_y;
    t_offs      x_offset;
    t_gain      y_from_touch_x;
    t_gain      y_from_touch_y;
    t_offs      y_offset;
    modport source(output valid, status, divider, x_from_touch_x, x_from_touch_y, x_offset,
                   y_from_touch_x, y_from_touch_y, y_offset, input ready);
    modport sink(input valid, status, divider, x_from_touch_x, x_from_touch_y, x_offset,
                 y_from_touch_x, y_from_touch_y, y_offset, output ready);
endinterface

// File: rtl/core/tpc_seq.sv
// Program sequencer: step counter, control ROM readout and conditional jump.
// Depends on tpc_pkg for the control word and the ROM contents.
module tpc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_acc_zero,
    output tpc_pkg::t_uword o_cw,
    output logic            o_busy,
    output tpc_pkg::t_fin   o_fin
);
    import tpc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_cw;

    always_comb begin
        w_cw    = '0;
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_pc    = '0;
                end
            end
            S_RUN: begin
                w_cw = rom_word(r_pc);
                if (w_cw.done) begin
                    n_state = S_IDLE;
                end else if (w_cw.jmp_zero && i_acc_zero) begin
                    n_pc = w_cw.jmp_tgt;
                end else begin
                    n_pc = r_pc + PC_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_cw         = w_cw;
    assign o_busy       = (r_state == S_RUN);
    assign o_fin.valid  = (r_state == S_RUN) && w_cw.done;
    assign o_fin.status = w_cw.status;

endmodule

// File: rtl/core/tpc_dp.sv
// Datapath: point stores, operand select, shared multiplier and accumulator.
// Depends on tpc_pkg; driven by control words from tpc_seq.
module tpc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tpc_pkg::t_dp_cmd                 i_cmd,
    input  tpc_pkg::t_point                  i_point,
    input  tpc_pkg::t_uword                  i_cw,
    output logic [tpc_pkg::CNT_W-1:0]        o_count,
    output logic signed [tpc_pkg::ACC_W-1:0] o_acc,
    output logic                             o_acc_zero
);
    import tpc_pkg::*;

    logic [CNT_W-1:0]         r_count;
    t_coord                   r_dx [NPTS];
    t_coord                   r_dy [NPTS];
    t_coord                   r_tx [NPTS];
    t_coord                   r_ty [NPTS];
    t_coord                   w_a_hi, w_a_lo, w_b_hi, w_b_lo;
    logic signed [DIFF_W-1:0] w_a_diff, w_b_diff;
    logic signed [PAIR_W-1:0] w_op_a;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     w_wr;

    // Point count and stores; drop points once all three are held.
    assign w_wr = i_cmd.add && (r_count < CNT_W'(NPTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (w_wr) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_dx[r_count[IDX_W-1:0]] <= i_point.dx;
            r_dy[r_count[IDX_W-1:0]] <= i_point.dy;
            r_tx[r_count[IDX_W-1:0]] <= i_point.tx;
            r_ty[r_count[IDX_W-1:0]] <= i_point.ty;
        end
    end

    always_comb begin
        w_a_hi = r_tx[i_cw.a_i];
        w_a_lo = r_tx[i_cw.a_j];
        case (i_cw.a_src)
            SRC_DX: begin w_a_hi = r_dx[i_cw.a_i]; w_a_lo = r_dx[i_cw.a_j]; end
            SRC_DY: begin w_a_hi = r_dy[i_cw.a_i]; w_a_lo = r_dy[i_cw.a_j]; end
            SRC_TY: begin w_a_hi = r_ty[i_cw.a_i]; w_a_lo = r_ty[i_cw.a_j]; end
            default: ;
        endcase
    end

    always_comb begin
        w_b_hi = r_ty[i_cw.b_i];
        w_b_lo = r_ty[i_cw.b_j];
        case (i_cw.b_src)
            SRC_DX: begin w_b_hi = r_dx[i_cw.b_i]; w_b_lo = r_dx[i_cw.b_j]; end
            SRC_DY: begin w_b_hi = r_dy[i_cw.b_i]; w_b_lo = r_dy[i_cw.b_j]; end
            SRC_TX: begin w_b_hi = r_tx[i_cw.b_i]; w_b_lo = r_tx[i_cw.b_j]; end
            default: ;
        endcase
    end

    assign w_a_diff = $signed({1'b0, w_a_hi}) - (i_cw.a_sub ? $signed({1'b0, w_a_lo})
                                                            : $signed(DIFF_W'(0)));
    assign w_b_diff = $signed({1'b0, w_b_hi}) - (i_cw.b_sub ? $signed({1'b0, w_b_lo})
                                                            : $signed(DIFF_W'(0)));

    // Chained products reuse the previous product, which is a non-negative
    // touch-by-display pair and fits the narrower operand.
    assign w_op_a = (i_cw.a_src == SRC_PROD) ? $signed(r_prod[PAIR_W-1:0])
                                             : PAIR_W'(w_a_diff);
    assign w_mul  = PROD_W'(w_op_a) * PROD_W'(w_b_diff);

    always_ff @(posedge i_clk) begin
        if (i_cw.mul) begin
            r_prod <= w_mul;
        end
    end

    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        case (i_cw.acc_op)
            ACC_LOAD: r_acc <= w_prod_ext;
            ACC_ADD:  r_acc <= r_acc + w_prod_ext;
            ACC_SUB:  r_acc <= r_acc - w_prod_ext;
            default:  ;
        endcase
    end

    assign o_count    = r_count;
    assign o_acc      = r_acc;
    assign o_acc_zero = (r_acc == '0);

endmodule

// File: rtl/core/three_point_touch_calibration.sv
// Three-point touch calibration: start, add and short calibrate answer without the program, a full
// solve runs it and stops early on a zero divider; one request at a time (next accepted once the
// result register frees). The full solve is paced by the shared multiplier: 34 products through
// one unit, one per step, then two steps to finish the Y offset and write it out.
// Reset (synchronous, active low) clears the point count, the sequencer and the result valid;
// the point stores hold anything until written and are never read before that.
// Depends on tpc_pkg, tpc_if, tpc_seq and tpc_dp.
module three_point_touch_calibration (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpc_in_if.sink    i_req,
    tpc_out_if.source o_rsp
);
    import tpc_pkg::*;

    t_uword           w_cw;
    logic             w_busy;
    t_fin             w_fin;
    logic [CNT_W-1:0] w_count;
    logic signed [ACC_W-1:0] w_acc;
    logic             w_acc_zero;
    logic             w_accept;
    logic             w_cal_go;
    t_dp_cmd          w_cmd;
    t_point           w_point;

    logic    r_out_valid;
    t_status r_status;
    t_gain   r_divider, r_xtx, r_xty, r_ytx, r_yty;
    t_offs   r_xoff, r_yoff;

    // Take a request only while the sequencer is idle and the result
    // register is empty or being drained in this cycle.
    assign i_req.ready = !w_busy && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // A full solve needs all three points; anything else answers at once.
    assign w_cal_go  = w_accept && (i_req.mode == MODE_CAL) && (w_count == CNT_W'(NPTS));
    assign w_cmd.clear = w_accept && (i_req.mode == MODE_START);
    assign w_cmd.add   = w_accept && (i_req.mode == MODE_ADD);

    assign w_point.dx = i_req.display_x;
    assign w_point.dy = i_req.display_y;
    assign w_point.tx = i_req.touch_x;
    assign w_point.ty = i_req.touch_y;

    tpc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cal_go),
        .i_acc_zero (w_acc_zero),
        .o_cw       (w_cw),
        .o_busy     (w_busy),
        .o_fin      (w_fin)
    );

    tpc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_point    (w_point),
        .i_cw       (w_cw),
        .o_count    (w_count),
        .o_acc      (w_acc),
        .o_acc_zero (w_acc_zero)
    );

    // Result valid: set by an immediate answer or by the end of the program,
    // cleared when the response is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= !w_cal_go;
        end else if (w_fin.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: zero every coefficient on a new request, then let the
    // program write each one from the accumulator as it completes.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= (i_req.mode == MODE_CAL) ? ST_FEW : ST_NONE;
            r_divider <= '0;
            r_xtx     <= '0;
            r_xty     <= '0;
            r_xoff    <= '0;
            r_ytx     <= '0;
            r_yty     <= '0;
            r_yoff    <= '0;
        end else begin
            if (w_fin.valid) begin
                r_status <= w_fin.status;
            end
            case (w_cw.wr)
                WR_DIV:  r_divider <= w_acc[GAIN_W-1:0];
                WR_XTX:  r_xtx     <= w_acc[GAIN_W-1:0];
                WR_XTY:  r_xty     <= w_acc[GAIN_W-1:0];
                WR_XOFF: r_xoff    <= w_acc[OFFS_W-1:0];
                WR_YTX:  r_ytx     <= w_acc[GAIN_W-1:0];
                WR_YTY:  r_yty     <= w_acc[GAIN_W-1:0];
                WR_YOFF: r_yoff    <= w_acc[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.divider        = r_divider;
    assign o_rsp.x_from_touch_x = r_xtx;
    assign o_rsp.x_from_touch_y = r_xty;
    assign o_rsp.x_offset       = r_xoff;
    assign o_rsp.y_from_touch_x = r_ytx;
    assign o_rsp.y_from_touch_y = r_yty;
    assign o_rsp.y_offset       = r_yoff;

    // The program must finish into an empty result register.
    a_fin_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin.valid |-> !r_out_valid)
        else $error("program finished while a result was pending");

    // The sequencer starts only from an accepted calibrate request.
    a_start_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_busy) |-> $past(w_accept) && $past(i_req.mode == MODE_CAL))
        else $error("sequencer started without a calibrate request");

    // Anything but a valid solve carries zero coefficients (checked on the divider, x_from_touch_x and both offsets).
    a_zero_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |->
            (r_divider == '0) && (r_xtx == '0) && (r_xoff == '0) && (r_yoff == '0))
        else $error("coefficients nonzero on a failed or non-solve result");

    // A valid solve never reports a zero divider.
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_OK)) |-> (r_divider != '0))
        else $error("valid result with zero divider");

endmodule

// File: verif/tb_three_point_touch_calibration.sv
// Self-checking testbench of the three-point touch calibration block: directed and random
// requests, each result compared with an in-bench calibration predictor.
// Depends on tpc_pkg, tpc_if and the three_point_touch_calibration RTL.
module tb_three_point_touch_calibration;
    import tpc_pkg::*;

    // Mode 3 has no function in the block; it must change nothing.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam t_coord     COORD_MAX   = '1;

    localparam int TOTAL_ITEMS    = 800;
    localparam int IDLE_PERCENT   = 29;
    // Allow for a full solve and long stalls on both sides many times over.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 48;
    localparam int QUIET_FIRST    = 350;
    localparam int QUIET_LAST     = 500;

    // One expected response, laid out like the response channel.
    typedef struct packed {
        t_status status;
        t_gain   divider;
        t_gain   x_from_touch_x;
        t_gain   x_from_touch_y;
        t_offs   x_offset;
        t_gain   y_from_touch_x;
        t_gain   y_from_touch_y;
        t_offs   y_offset;
    } t_coeff_set;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tpc_in_if  req ();
    tpc_out_if rsp ();

    three_point_touch_calibration dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: points held since the last start, and the stored points.
    int         held_points = 0;
    longint     cal_dx[NPTS];
    longint     cal_dy[NPTS];
    longint     cal_tx[NPTS];
    longint     cal_ty[NPTS];

    t_coeff_set expected_coeffs[$];
    int         mismatch_count = 0;
    int         sent_items     = 0;
    int         stall_cycles   = 0;
    bit         quiet          = 1'b0;

    // Cross term (a0-a2)(b1-b2) - (a1-a2)(b0-b2), used for the divider and all four gains.
    function automatic longint cross_term(input longint a[NPTS], input longint b[NPTS]);
        return (a[0] - a[2]) * (b[1] - b[2]) - (a[1] - a[2]) * (b[0] - b[2]);
    endfunction

    // Offset numerator for one display axis, built from the stored touch samples.
    function automatic longint offset_numerator(input longint d[NPTS]);
        return cal_ty[0] * (cal_tx[2] * d[1] - cal_tx[1] * d[2])
             + cal_ty[1] * (cal_tx[0] * d[2] - cal_tx[2] * d[0])
             + cal_ty[2] * (cal_tx[1] * d[0] - cal_tx[0] * d[1]);
    endfunction

    // Advance the predictor by one accepted request and return the response it must cause.
    function automatic t_coeff_set predict_calibration(input logic [1:0] mode,
                                                       input t_coord dx, input t_coord dy,
                                                       input t_coord tx, input t_coord ty);
        t_coeff_set c;
        longint     touch_det;
        c = '0;
        c.status = ST_NONE;
        case (mode)
            MODE_START: begin
                held_points = 0;
            end
            MODE_ADD: begin
                // Drop the point silently once three are held.
                if (held_points < NPTS) begin
                    cal_dx[held_points] = dx;
                    cal_dy[held_points] = dy;
                    cal_tx[held_points] = tx;
                    cal_ty[held_points] = ty;
                    held_points++;
                end
            end
            MODE_CAL: begin
                if (held_points != NPTS) begin
                    c.status = ST_FEW;
                end else begin
                    touch_det = cross_term(cal_tx, cal_ty);
                    if (touch_det == 0) begin
                        c.status = ST_ZERO;
                    end else begin
                        c.status         = ST_OK;
                        c.divider        = t_gain'(touch_det);
                        c.x_from_touch_x = t_gain'(cross_term(cal_dx, cal_ty));
                        c.x_from_touch_y = t_gain'(cross_term(cal_tx, cal_dx));
                        c.x_offset       = t_offs'(offset_numerator(cal_dx));
                        c.y_from_touch_x = t_gain'(cross_term(cal_dy, cal_ty));
                        c.y_from_touch_y = t_gain'(cross_term(cal_tx, cal_dy));
                        c.y_offset       = t_offs'(offset_numerator(cal_dy));
                    end
                end
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] response mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // Compare one accepted response against the oldest pending expectation.
    task automatic check_result();
        t_coeff_set want;
        if (expected_coeffs.size() == 0) begin
            report_mismatch("response with nothing pending (status)", rsp.status, 0);
            return;
        end
        want = expected_coeffs.pop_front();
        if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
        if (rsp.divider !== want.divider)
            report_mismatch("divider", rsp.divider, want.divider);
        if (rsp.x_from_touch_x !== want.x_from_touch_x)
            report_mismatch("x_from_touch_x", rsp.x_from_touch_x, want.x_from_touch_x);
        if (rsp.x_from_touch_y !== want.x_from_touch_y)
            report_mismatch("x_from_touch_y", rsp.x_from_touch_y, want.x_from_touch_y);
        if (rsp.x_offset !== want.x_offset)
            report_mismatch("x_offset", rsp.x_offset, want.x_offset);
        if (rsp.y_from_touch_x !== want.y_from_touch_x)
            report_mismatch("y_from_touch_x", rsp.y_from_touch_x, want.y_from_touch_x);
        if (rsp.y_from_touch_y !== want.y_from_touch_y)
            report_mismatch("y_from_touch_y", rsp.y_from_touch_y, want.y_from_touch_y);
        if (rsp.y_offset !== want.y_offset)
            report_mismatch("y_offset", rsp.y_offset, want.y_offset);
    endtask

    // Send one request: idle at random first, then hold valid until the block takes it.
    // Valid stays high on return, so back-to-back requests drop it only for a random idle.
    task automatic send_request(input logic [1:0] mode, input t_coord dx, input t_coord dy,
                                input t_coord tx, input t_coord ty);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.mode      <= mode;
        req.display_x <= dx;
        req.display_y <= dy;
        req.touch_x   <= tx;
        req.touch_y   <= ty;
        @(posedge i_clk);
        while (req.ready !== 1'b1) @(posedge i_clk);
        expected_coeffs.push_back(predict_calibration(mode, dx, dy, tx, ty));
        sent_items++;
    endtask

    // Favor the ends of the coordinate range now and then.
    function automatic t_coord random_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return COORD_MAX;
            default: return t_coord'($urandom());
        endcase
    endfunction

    // Calibrate with zero, one and two points held: every one must report too few points.
    task automatic test_short_calibrate();
        send_request(MODE_CAL, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(MODE_ADD, 12'd100, 12'd200, 12'd300, 12'd400);
        send_request(MODE_CAL, '0, '0, '0, '0);
        send_request(MODE_ADD, 12'd3000, 12'd150, 12'd3900, 12'd250);
        send_request(MODE_CAL, '0, '0, '0, '0);
    endtask

    // Full solve at the range corners (largest positive divider), then a fourth point
    // that must be ignored so the calibration still uses the first three.
    task automatic test_full_solve_extremes();
        send_request(MODE_START, '0, '0, '0, '0);
        send_request(MODE_ADD, COORD_MAX, '0, COORD_MAX, '0);
        send_request(MODE_ADD, '0, COORD_MAX, '0, COORD_MAX);
        send_request(MODE_ADD, '0, '0, '0, '0);
        send_request(MODE_ADD, COORD_MAX, COORD_MAX, 12'd1234, 12'd2345);
        send_request(MODE_CAL, '0, '0, '0, '0);
    endtask

    // Hold points with the most negative divider and all-ones display coordinates, slip in
    // an unused mode, and check the solve is unaffected.
    task automatic test_unused_mode();
        send_request(MODE_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(MODE_ADD, COORD_MAX, COORD_MAX, '0, COORD_MAX);
        send_request(MODE_ADD, COORD_MAX, COORD_MAX, COORD_MAX, '0);
        send_request(MODE_ADD, COORD_MAX, COORD_MAX, '0, '0);
        send_request(MODE_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(MODE_CAL, '0, '0, '0, '0);
    endtask

    // Three touches at one spot give a zero divider; a start afterwards clears the points.
    task automatic test_zero_divider();
        send_request(MODE_START, '0, '0, '0, '0);
        send_request(MODE_ADD, 12'd10, 12'd20, 12'd2048, 12'd2048);
        send_request(MODE_ADD, 12'd4000, 12'd30, 12'd2048, 12'd2048);
        send_request(MODE_ADD, 12'd50, 12'd3900, 12'd2048, 12'd2048);
        send_request(MODE_CAL, '0, '0, '0, '0);
        send_request(MODE_START, '0, '0, '0, '0);
        send_request(MODE_CAL, '0, '0, '0, '0);
    endtask

    // Mostly well-formed calibration runs with random points, some with a collinear touch
    // set, the rest short or long point lists and loose noise requests. One stretch runs
    // with both sides never idling.
    task automatic test_random_traffic();
        int     n_points;
        bit     collinear;
        t_coord shared_tx;
        while (sent_items < TOTAL_ITEMS) begin
            quiet = (sent_items >= QUIET_FIRST && sent_items < QUIET_LAST);
            if ($urandom_range(99) < 80) begin
                n_points  = ($urandom_range(99) < 80) ? NPTS : int'($urandom_range(4));
                collinear = ($urandom_range(99) < 15);
                shared_tx = random_coord();
                send_request(MODE_START, random_coord(), random_coord(),
                             random_coord(), random_coord());
                for (int i = 0; i < n_points; i++)
                    send_request(MODE_ADD, random_coord(), random_coord(),
                                 collinear ? shared_tx : random_coord(), random_coord());
                send_request(MODE_CAL, random_coord(), random_coord(),
                             random_coord(), random_coord());
                // A second calibrate must reuse the same points.
                if ($urandom_range(9) == 0)
                    send_request(MODE_CAL, random_coord(), random_coord(),
                                 random_coord(), random_coord());
            end else begin
                repeat ($urandom_range(4, 1))
                    send_request(2'($urandom_range(3)), random_coord(), random_coord(),
                                 random_coord(), random_coord());
            end
        end
        quiet = 1'b0;
    endtask

    // Response side: check each accepted response, then pick the next ready at random outside the quiet stretch.
    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_result();
            rsp.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: end the run if neither channel moves a request for too long.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("three_point_touch_calibration verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        req.valid     <= 1'b0;
        req.mode      <= MODE_START;
        req.display_x <= '0;
        req.display_y <= '0;
        req.touch_x   <= '0;
        req.touch_y   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_calibrate();
        test_full_solve_extremes();
        test_unused_mode();
        test_zero_divider();
        test_random_traffic();

        req.valid <= 1'b0;
        // Drain outstanding responses, then watch a little longer for strays.
        while (expected_coeffs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("three_point_touch_calibration verification clean");
        else
            $display("three_point_touch_calibration verification failed");
        $finish;
    end

endmodule
